// ===== rtl/imutgr_pkg.sv =====
// ----------------------------------------------------------------------------
// imutgr_pkg
// Shared types, constants and the arctangent table for the tilt and gravity
// removal block.
// ----------------------------------------------------------------------------
package imutgr_pkg;

    // CORDIC depth, capped by the length of the arctangent table
    localparam int CordicStages = 16;
    localparam int TableLen     = 24;
    localparam int Stages       = (CordicStages > TableLen) ? TableLen : CordicStages;
    localparam int IterW        = $clog2(TableLen);

    typedef logic signed [32:0] t_mop;    // multiplier operand
    typedef logic signed [65:0] t_prod;   // multiplier product
    typedef logic signed [33:0] t_cw;     // CORDIC x/y word
    typedef logic signed [24:0] t_ang;    // angle, 2^-20 rad

    typedef struct packed {
        logic start;
        logic rotate;   // 1: rotation (sin/cos), 0: vectoring (atan2)
    } t_cor_cmd;

    localparam t_mop AccScale   = 33'sd160727;   // 9.81*4096/16384, Q16
    localparam t_mop GyroScale  = 33'sd600020;   // rad per LSB per us, Q52
    localparam t_mop GravUnits  = 33'sd40182;    // 9.81 m/s^2 in 1/4096
    localparam t_mop WeightOne  = 33'sd65536;

    localparam t_ang AngPi      = 25'sd3294199;
    localparam t_ang AngTwoPi   = 25'sd6588397;
    localparam t_ang AngHalfPi  = 25'sd1647099;
    localparam t_cw  InvGainQ30 = 34'sd652032874;

    function automatic t_ang atan_entry(input logic [IterW-1:0] idx);
        t_ang v;
        case (idx)
            5'd0:    v = 25'sd823550;
            5'd1:    v = 25'sd486170;
            5'd2:    v = 25'sd256879;
            5'd3:    v = 25'sd130396;
            5'd4:    v = 25'sd65451;
            5'd5:    v = 25'sd32757;
            5'd6:    v = 25'sd16383;
            5'd7:    v = 25'sd8192;
            5'd8:    v = 25'sd4096;
            5'd9:    v = 25'sd2048;
            5'd10:   v = 25'sd1024;
            5'd11:   v = 25'sd512;
            5'd12:   v = 25'sd256;
            5'd13:   v = 25'sd128;
            5'd14:   v = 25'sd64;
            5'd15:   v = 25'sd32;
            5'd16:   v = 25'sd16;
            5'd17:   v = 25'sd8;
            5'd18:   v = 25'sd4;
            5'd19:   v = 25'sd2;
            5'd20:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/imutgr_mul.sv =====
// ----------------------------------------------------------------------------
// imutgr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module imutgr_mul (
    input  logic              i_clk,
    input  imutgr_pkg::t_mop  i_a,
    input  imutgr_pkg::t_mop  i_b,
    output imutgr_pkg::t_prod o_p
);

    imutgr_pkg::t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/imutgr_isqrt.sv =====
// ----------------------------------------------------------------------------
// imutgr_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module imutgr_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_val,
    output logic        o_busy,
    output logic [23:0] o_root
);

    logic        r_busy;
    logic [47:0] r_v;
    logic [47:0] r_res;
    logic [47:0] r_bit;
    logic [47:0] trial;
    logic        take;

    assign trial = r_res + r_bit;
    assign take  = (r_v >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= 48'h4000_0000_0000;
        end else if (r_busy) begin
            if (take) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[23:0];

endmodule

// ===== rtl/imutgr_cordic.sv =====
// ----------------------------------------------------------------------------
// imutgr_cordic
// Shared CORDIC unit, one micro-rotation per cycle. Vectoring gives atan2,
// rotation gives scaled sine and cosine.
// ----------------------------------------------------------------------------
module imutgr_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imutgr_pkg::t_cor_cmd  i_cmd,
    input  imutgr_pkg::t_cw       i_x,
    input  imutgr_pkg::t_cw       i_y,
    input  imutgr_pkg::t_ang      i_z,
    output logic                  o_busy,
    output imutgr_pkg::t_cw       o_x,
    output imutgr_pkg::t_cw       o_y,
    output imutgr_pkg::t_ang      o_z
);

    logic                         r_busy;
    logic [imutgr_pkg::IterW-1:0] r_i;
    logic                         r_rot;
    logic                         r_zero;
    imutgr_pkg::t_cw              r_x;
    imutgr_pkg::t_cw              r_y;
    imutgr_pkg::t_ang             r_z;

    imutgr_pkg::t_cw              xs;
    imutgr_pkg::t_cw              ys;
    logic                         sub;
    logic                         last;

    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign sub  = r_rot ? (r_z >= 0) : !(r_y > 0);
    assign last = (r_i == imutgr_pkg::IterW'(imutgr_pkg::Stages - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            if (last) begin
                r_busy <= 1'b0;
            end
            r_i <= r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rot <= i_cmd.rotate;
            if (i_cmd.rotate) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_zero <= 1'b0;
            end else begin
                // left half plane: turn by pi first
                r_zero <= (i_x == 0) && (i_y == 0);
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? imutgr_pkg::AngPi : -imutgr_pkg::AngPi;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end
        end else if (r_busy) begin
            if (sub) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - imutgr_pkg::atan_entry(r_i);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + imutgr_pkg::atan_entry(r_i);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_zero ? '0 : r_z;

endmodule

// ===== rtl/imu_tilt_gravity_removal.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_gravity_removal
// Roll/pitch complementary filter with gravity removal, built around one
// shared multiplier, one shared CORDIC unit and an iterative square root.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one raw sample item (accel x/y/z, rate x/y, elapsed us)
//   is taken when i_in_valid is high and o_in_stall is low. o_in_stall is
//   high while an item is being worked on, so one item is in flight.
//   Output channel: o_out_valid with registered linear acceleration and
//   filtered angles; the item leaves when i_out_stall is low. A finished
//   item waits in the output register, and the next input item is taken
//   meanwhile; only a second finished item waits for the slot to free.
//   Sequence: four CORDIC passes dominate (one micro-rotation per cycle);
//   the square root runs under the roll arctangent and can hold the pitch
//   launch until it is done; the remaining sequencer steps drive the shared
//   multiplier. The input is free again once the result has gone to the
//   output register.
//   Reset (i_rst_n low, synchronous): estimates go to zero, blend weight to
//   64225 (about 0.98), both channels idle. No clearing pass is needed.
//   blend_weight is written over the APB port at byte address 0; values
//   above 65536 act as 65536.
// ----------------------------------------------------------------------------
module imu_tilt_gravity_removal (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic        [15:0] i_elapsed_us,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_lin_acc_x,
    output logic signed [17:0] o_lin_acc_y,
    output logic signed [17:0] o_lin_acc_z,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [1:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    // sequencer states
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MAX    = 5'd1;
    localparam logic [4:0] ST_MAY    = 5'd2;
    localparam logic [4:0] ST_MAZ    = 5'd3;
    localparam logic [4:0] ST_MAY2   = 5'd4;
    localparam logic [4:0] ST_MAZ2   = 5'd5;
    localparam logic [4:0] ST_MGXU   = 5'd6;
    localparam logic [4:0] ST_MGYU   = 5'd7;
    localparam logic [4:0] ST_MDR    = 5'd8;
    localparam logic [4:0] ST_MDP    = 5'd9;
    localparam logic [4:0] ST_VRGO   = 5'd10;
    localparam logic [4:0] ST_VROLL  = 5'd11;
    localparam logic [4:0] ST_VPGO   = 5'd12;
    localparam logic [4:0] ST_VPITCH = 5'd13;
    localparam logic [4:0] ST_BR1    = 5'd14;
    localparam logic [4:0] ST_BR2    = 5'd15;
    localparam logic [4:0] ST_BP1    = 5'd16;
    localparam logic [4:0] ST_BP2    = 5'd17;
    localparam logic [4:0] ST_BPE    = 5'd18;
    localparam logic [4:0] ST_RROLL  = 5'd19;
    localparam logic [4:0] ST_RPGO   = 5'd20;
    localparam logic [4:0] ST_RPITCH = 5'd21;
    localparam logic [4:0] ST_G1     = 5'd22;
    localparam logic [4:0] ST_G2     = 5'd23;
    localparam logic [4:0] ST_G3     = 5'd24;
    localparam logic [4:0] ST_G4     = 5'd25;
    localparam logic [4:0] ST_G5     = 5'd26;
    localparam logic [4:0] ST_G6     = 5'd27;
    localparam logic [4:0] ST_OUT    = 5'd28;

    localparam logic [1:0]  ADDR_BLEND   = 2'd0;
    localparam logic [16:0] BLEND_RESET  = 17'd64225;

    // rounding right shift, half up
    function automatic imutgr_pkg::t_prod rnd(input imutgr_pkg::t_prod v, input int s);
        return (v + (66'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [23:0] sat24(input imutgr_pkg::t_prod v);
        logic signed [23:0] r;
        if (v > 66'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -66'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v > 19'sd131071) begin
            r = 18'sd131071;
        end else if (v < -19'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] ang_out(input logic signed [23:0] est);
        logic signed [24:0] v;
        logic signed [15:0] r;
        v = (25'(est) + 25'sd64) >>> 7;
        if (v > 25'sd32767) begin
            r = 16'sd32767;
        end else if (v < -25'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // control
    logic [4:0]  r_state;
    logic [4:0]  n_state;
    logic [16:0] r_blend;
    logic        r_out_valid;
    logic signed [23:0] r_roll_est;
    logic signed [23:0] r_pitch_est;

    // working registers
    logic signed [15:0] r_axr, r_ayr, r_azr, r_gxr, r_gyr;
    logic        [15:0] r_us;
    logic signed [17:0] r_w;
    logic signed [17:0] r_ax, r_ay, r_az;
    logic signed [17:0] r_gx, r_gy, r_gz;
    imutgr_pkg::t_prod  r_acc;
    imutgr_pkg::t_mop   r_t1;
    logic signed [20:0] r_droll, r_dpitch;
    imutgr_pkg::t_ang   r_roll_acc, r_pitch_acc;
    imutgr_pkg::t_mop   r_sr, r_cr, r_sp, r_cp;
    logic               r_flip;

    // output registers
    logic signed [17:0] r_lin_x, r_lin_y, r_lin_z;
    logic signed [15:0] r_roll_o, r_pitch_o;

    // shared units
    imutgr_pkg::t_mop     mul_a, mul_b;
    imutgr_pkg::t_prod    mul_p;
    imutgr_pkg::t_cor_cmd cor_cmd;
    imutgr_pkg::t_cw      cor_xi, cor_yi, cor_xo, cor_yo;
    imutgr_pkg::t_ang     cor_zi, cor_zo;
    logic                 cor_busy;
    logic                 sq_start, sq_busy;
    logic [23:0]          sq_root;

    // angle reduction for the rotation passes
    imutgr_pkg::t_ang     ang_sel, ang_wrap, ang_fold;
    logic                 fold_flip;

    logic in_acc, out_acc, out_free, cfg_wr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    imutgr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    imutgr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cor_cmd),
        .i_x     (cor_xi),
        .i_y     (cor_yi),
        .i_z     (cor_zi),
        .o_busy  (cor_busy),
        .o_x     (cor_xo),
        .o_y     (cor_yo),
        .o_z     (cor_zo)
    );

    imutgr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   ({r_acc[31:0], 16'b0}),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // estimates stay within +-2^23, so one wrap step suffices
    always_comb begin
        ang_sel   = (r_state == ST_BPE) ? 25'(r_roll_est) : 25'(r_pitch_est);
        if (ang_sel > imutgr_pkg::AngPi) begin
            ang_wrap = ang_sel - imutgr_pkg::AngTwoPi;
        end else if (ang_sel < -imutgr_pkg::AngPi) begin
            ang_wrap = ang_sel + imutgr_pkg::AngTwoPi;
        end else begin
            ang_wrap = ang_sel;
        end
        fold_flip = 1'b1;
        if (ang_wrap > imutgr_pkg::AngHalfPi) begin
            ang_fold = ang_wrap - imutgr_pkg::AngPi;
        end else if (ang_wrap < -imutgr_pkg::AngHalfPi) begin
            ang_fold = ang_wrap + imutgr_pkg::AngPi;
        end else begin
            ang_fold  = ang_wrap;
            fold_flip = 1'b0;
        end
    end

    // CORDIC launch
    always_comb begin
        cor_cmd.start  = 1'b0;
        cor_cmd.rotate = 1'b0;
        cor_xi         = '0;
        cor_yi         = '0;
        cor_zi         = ang_fold;
        case (r_state)
            ST_VRGO: begin
                cor_cmd.start = 1'b1;
                cor_xi        = 34'(r_azr) <<< 8;
                cor_yi        = 34'(r_ayr) <<< 8;
            end
            ST_VPGO: begin
                cor_cmd.start = !sq_busy;
                cor_xi        = $signed({10'b0, sq_root});
                cor_yi        = -(34'(r_axr) <<< 8);
            end
            ST_BPE, ST_RPGO: begin
                cor_cmd.start  = 1'b1;
                cor_cmd.rotate = 1'b1;
                cor_xi         = imutgr_pkg::InvGainQ30;
            end
            default: begin
                cor_cmd.start = 1'b0;
            end
        endcase
    end

    assign sq_start = (r_state == ST_MGYU);

    // multiplier operand select; product is consumed one state later
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MAX:  begin mul_a = 33'(r_axr); mul_b = imutgr_pkg::AccScale; end
            ST_MAY:  begin mul_a = 33'(r_ayr); mul_b = imutgr_pkg::AccScale; end
            ST_MAZ:  begin mul_a = 33'(r_azr); mul_b = imutgr_pkg::AccScale; end
            ST_MAY2: begin mul_a = 33'(r_ayr); mul_b = 33'(r_ayr); end
            ST_MAZ2: begin mul_a = 33'(r_azr); mul_b = 33'(r_azr); end
            ST_MGXU: begin mul_a = 33'(r_gxr); mul_b = $signed({17'b0, r_us}); end
            ST_MGYU: begin mul_a = 33'(r_gyr); mul_b = $signed({17'b0, r_us}); end
            ST_MDR, ST_MDP: begin
                mul_a = r_t1;
                mul_b = imutgr_pkg::GyroScale;
            end
            ST_BR1: begin
                mul_a = 33'(r_w);
                mul_b = 33'(r_roll_est) + 33'(r_droll);
            end
            ST_BR2: begin
                mul_a = imutgr_pkg::WeightOne - 33'(r_w);
                mul_b = 33'(r_roll_acc);
            end
            ST_BP1: begin
                mul_a = 33'(r_w);
                mul_b = 33'(r_pitch_est) + 33'(r_dpitch);
            end
            ST_BP2: begin
                mul_a = imutgr_pkg::WeightOne - 33'(r_w);
                mul_b = 33'(r_pitch_acc);
            end
            ST_G1:  begin mul_a = imutgr_pkg::GravUnits; mul_b = r_sp; end
            ST_G2:  begin mul_a = r_sr; mul_b = r_cp; end
            ST_G3:  begin mul_a = r_cr; mul_b = r_cp; end
            ST_G4, ST_G5: begin
                mul_a = imutgr_pkg::GravUnits;
                mul_b = r_t1;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_MAX;
            ST_VROLL:  if (!cor_busy) n_state = ST_VPGO;
            ST_VPGO:   if (!sq_busy) n_state = ST_VPITCH;
            ST_VPITCH: if (!cor_busy) n_state = ST_BR1;
            ST_RROLL:  if (!cor_busy) n_state = ST_RPGO;
            ST_RPITCH: if (!cor_busy) n_state = ST_G1;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            default:   n_state = r_state + 5'd1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_blend     <= BLEND_RESET;
            r_out_valid <= 1'b0;
            r_roll_est  <= '0;
            r_pitch_est <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr == ADDR_BLEND) begin
                r_blend <= pwdata[16:0];
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_BP1) begin
                r_roll_est <= sat24(rnd(r_acc + mul_p, 16));
            end
            if (r_state == ST_BPE) begin
                r_pitch_est <= sat24(rnd(r_acc + mul_p, 16));
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_axr <= i_accel_x;
                    r_ayr <= i_accel_y;
                    r_azr <= i_accel_z;
                    r_gxr <= i_rate_x;
                    r_gyr <= i_rate_y;
                    r_us  <= i_elapsed_us;
                    r_w   <= (r_blend > 17'd65536) ? 18'sd65536 : $signed({1'b0, r_blend});
                end
            end
            ST_MAY:  r_ax <= 18'(rnd(mul_p, 16));
            ST_MAZ:  r_ay <= 18'(rnd(mul_p, 16));
            ST_MAY2: r_az <= 18'(rnd(mul_p, 16));
            ST_MAZ2: r_acc <= mul_p;
            ST_MGXU: r_acc <= r_acc + mul_p;       // ay^2 + az^2
            ST_MGYU: r_t1 <= 33'(mul_p);
            ST_MDR:  r_t1 <= 33'(mul_p);
            ST_MDP:  r_droll <= 21'(rnd(mul_p, 32));
            ST_VRGO: r_dpitch <= 21'(rnd(mul_p, 32));
            ST_VROLL:  if (!cor_busy) r_roll_acc <= cor_zo;
            ST_VPITCH: if (!cor_busy) r_pitch_acc <= cor_zo;
            ST_BR2:  r_acc <= mul_p;
            ST_BP2:  r_acc <= mul_p;
            ST_BPE:  r_flip <= fold_flip;
            ST_RROLL: begin
                if (!cor_busy) begin
                    r_sr <= r_flip ? -33'(cor_yo) : 33'(cor_yo);
                    r_cr <= r_flip ? -33'(cor_xo) : 33'(cor_xo);
                end
            end
            ST_RPGO: r_flip <= fold_flip;
            ST_RPITCH: begin
                if (!cor_busy) begin
                    r_sp <= r_flip ? -33'(cor_yo) : 33'(cor_yo);
                    r_cp <= r_flip ? -33'(cor_xo) : 33'(cor_xo);
                end
            end
            ST_G2: r_gx <= -18'(rnd(mul_p, 30));
            ST_G3: r_t1 <= 33'(rnd(mul_p, 30));
            ST_G4: r_t1 <= 33'(rnd(mul_p, 30));
            ST_G5: r_gy <= 18'(rnd(mul_p, 30));
            ST_G6: r_gz <= 18'(rnd(mul_p, 30));
            ST_OUT: begin
                if (out_free) begin
                    r_lin_x   <= sat18(19'(r_ax) - 19'(r_gx));
                    r_lin_y   <= sat18(19'(r_ay) - 19'(r_gy));
                    r_lin_z   <= sat18(19'(r_az) - 19'(r_gz));
                    r_roll_o  <= ang_out(r_roll_est);
                    r_pitch_o <= ang_out(r_pitch_est);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_lin_acc_x   = r_lin_x;
    assign o_lin_acc_y   = r_lin_y;
    assign o_lin_acc_z   = r_lin_z;
    assign o_roll_angle  = r_roll_o;
    assign o_pitch_angle = r_pitch_o;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BLEND) ? {15'b0, r_blend} : 32'b0;

    // ---- checks ----
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!cor_busy && !sq_busy))
        else $error("shared unit busy while idle");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_MAX))
        else $error("sequencer did not start on accepted item");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output step");

    a_pitch_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VPITCH) |-> !sq_busy)
        else $error("pitch arctangent launched before square root finished");

endmodule

// ===== dv/tb_imu_tilt_gravity_removal.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_tilt_gravity_removal
// Self-checking bench for the tilt estimator with gravity removal. A short
// directed table runs first, then random samples (realistic, extreme and
// noise), over several blend weights. Every result is compared with a local
// bit-accurate model of the filter, CORDIC and gravity subtraction.
// ----------------------------------------------------------------------------
module tb_imu_tilt_gravity_removal;

    localparam int  ClkHalf    = 6;
    localparam int  NumRandom  = 1730;
    localparam int  IdleLimit  = 20000;   // cycles without any item moving
    localparam int  DrainWait  = 200;     // longer than the block latency
    localparam int  HoldCycles = 2500;    // long receiver hold-off

    // one input sample and one result item
    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy;
        logic        [15:0] us;
        bit                 typed;        // angles below were written by hand
        logic signed [15:0] roll, pitch;
    } t_sample;

    typedef struct {
        logic signed [17:0] lx, ly, lz;
        logic signed [15:0] roll, pitch;
    } t_motion;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic signed [15:0] i_rate_x = '0, i_rate_y = '0;
    logic        [15:0] i_elapsed_us = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [17:0] o_lin_acc_x, o_lin_acc_y, o_lin_acc_z;
    logic signed [15:0] o_roll_angle, o_pitch_angle;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic        [1:0]  paddr = '0;
    logic        [31:0] pwdata = '0;
    logic        [31:0] prdata;
    logic               pready;

    imu_tilt_gravity_removal u_top (.*);

    always #(ClkHalf) i_clk = ~i_clk;

    // ---------------------------------------------------------------- model
    // filter state and weight, kept in step with the block
    longint    roll_est, pitch_est;
    bit [16:0] weight;
    longint    arctan_steps [imutgr_pkg::TableLen] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring: angle of (x, y) in 2^-20 rad
    function automatic longint tilt_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(imutgr_pkg::AngPi) : -longint'(imutgr_pkg::AngPi);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < imutgr_pkg::Stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_steps[i];
            end else begin
                x -= dx; y += dy; z -= arctan_steps[i];
            end
        end
        return z;
    endfunction

    // rotation: sine and cosine in Q30
    task automatic sin_cos(input longint a, output longint s, output longint c);
        longint x, y, dx, dy;
        bit     flip;
        x = longint'(imutgr_pkg::InvGainQ30);
        y = 0;
        flip = 0;
        while (a > longint'(imutgr_pkg::AngPi)) a -= longint'(imutgr_pkg::AngTwoPi);
        while (a < -longint'(imutgr_pkg::AngPi)) a += longint'(imutgr_pkg::AngTwoPi);
        if (a > longint'(imutgr_pkg::AngHalfPi)) begin
            a -= longint'(imutgr_pkg::AngPi); flip = 1;
        end else if (a < -longint'(imutgr_pkg::AngHalfPi)) begin
            a += longint'(imutgr_pkg::AngPi); flip = 1;
        end
        for (int i = 0; i < imutgr_pkg::Stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x -= dx; y += dy; a -= arctan_steps[i];
            end else begin
                x += dx; y -= dy; a += arctan_steps[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint fuse(longint prev, longint d, longint acc_ang);
        longint w;
        w = (weight > 17'd65536) ? 65536 : longint'(weight);
        return clamp(round_half_up(w * (prev + d) + (65536 - w) * acc_ang, 16), 24);
    endfunction

    task automatic predict_motion(input t_sample s, output t_motion r);
        longint ax, ay, az, rr, pr, mag, dr, dp, sr, cr, sp, cp, gx, gy, gz;
        ax = round_half_up(longint'(s.ax) * imutgr_pkg::AccScale, 16);
        ay = round_half_up(longint'(s.ay) * imutgr_pkg::AccScale, 16);
        az = round_half_up(longint'(s.az) * imutgr_pkg::AccScale, 16);
        rr  = tilt_angle(longint'(s.ay) * 256, longint'(s.az) * 256);
        mag = int_sqrt(longint'(longint'(s.ay) * s.ay + longint'(s.az) * s.az) << 16);
        pr  = tilt_angle(-longint'(s.ax) * 256, mag);
        dr = round_half_up(longint'(s.gx) * longint'(s.us) * imutgr_pkg::GyroScale, 32);
        dp = round_half_up(longint'(s.gy) * longint'(s.us) * imutgr_pkg::GyroScale, 32);
        roll_est  = fuse(roll_est, dr, rr);
        pitch_est = fuse(pitch_est, dp, pr);
        sin_cos(roll_est, sr, cr);
        sin_cos(pitch_est, sp, cp);
        gx = -round_half_up(imutgr_pkg::GravUnits * sp, 30);
        gy = round_half_up(imutgr_pkg::GravUnits * round_half_up(sr * cp, 30), 30);
        gz = round_half_up(imutgr_pkg::GravUnits * round_half_up(cr * cp, 30), 30);
        r.lx    = 18'(clamp(ax - gx, 18));
        r.ly    = 18'(clamp(ay - gy, 18));
        r.lz    = 18'(clamp(az - gz, 18));
        r.roll  = 16'(clamp(round_half_up(roll_est, 7), 16));
        r.pitch = 16'(clamp(round_half_up(pitch_est, 7), 16));
    endtask

    // ---------------------------------------------------------- bookkeeping
    t_motion pending_motion [$];
    t_sample cur_sample;
    int      n_in, n_out, n_bad, idle_cycles, n_weights;
    bit      hold_done;

    wire in_fire  = i_in_valid & ~o_in_stall;
    wire out_fire = o_out_valid & ~i_out_stall;

    // handshakes are sampled at the falling edge, where every signal is stable
    always @(negedge i_clk) begin
        t_motion e;
        if (i_rst_n && in_fire) begin
            predict_motion(cur_sample, e);
            if (cur_sample.typed) begin
                e.roll  = cur_sample.roll;
                e.pitch = cur_sample.pitch;
            end
            pending_motion.push_back(e);
            n_in++;
        end
        if (i_rst_n && out_fire) begin
            n_out++;
            if (pending_motion.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("result %0d arrived with none expected", n_out);
            end else begin
                e = pending_motion.pop_front();
                if (e.lx !== o_lin_acc_x || e.ly !== o_lin_acc_y || e.lz !== o_lin_acc_z ||
                    e.roll !== o_roll_angle || e.pitch !== o_pitch_angle) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"result %0d: exp lin %0d %0d %0d ang %0d %0d,",
                                  " got lin %0d %0d %0d ang %0d %0d"},
                                 n_out, e.lx, e.ly, e.lz, e.roll, e.pitch,
                                 o_lin_acc_x, o_lin_acc_y, o_lin_acc_z,
                                 o_roll_angle, o_pitch_angle);
                end
            end
        end
    end

    // watchdog: too long without an item moving on either side
    always @(posedge i_clk) begin
        if (in_fire || out_fire || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: stall pattern in modes, plus one long hold-off mid run
    initial begin
        int mode, span;
        i_out_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 300);
            if (!hold_done && n_in > 600) begin
                hold_done = 1;
                @(posedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
            end
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 9) != 0);
                    default: i_out_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // --------------------------------------------------------------- sender
    int burst_left;

    task automatic send_sample(input t_sample s);
        bit f;
        // gap before the next burst
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        cur_sample   <= s;
        i_accel_x    <= s.ax;
        i_accel_y    <= s.ay;
        i_accel_z    <= s.az;
        i_rate_x     <= s.gx;
        i_rate_y     <= s.gy;
        i_elapsed_us <= s.us;
        i_in_valid   <= 1'b1;
        forever begin
            @(negedge i_clk);
            f = in_fire;
            @(posedge i_clk);
            if (f) break;
        end
    endtask

    // drain, let the block settle, then write blend_weight over APB
    task automatic set_weight(input bit [31:0] v);
        i_in_valid <= 1'b0;
        wait (pending_motion.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);            // register written at this edge
        weight = v[16:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        n_weights++;
    endtask

    function automatic t_sample mk(int ax, int ay, int az, int gx, int gy, int us,
                                   bit typed = 0, int roll = 0, int pitch = 0);
        t_sample s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.gx = 16'(gx); s.gy = 16'(gy); s.us = 16'(us);
        s.typed = typed; s.roll = 16'(roll); s.pitch = 16'(pitch);
        return s;
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int      k;
        k = $urandom_range(0, 9);
        s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (k < 5) begin
            // sensor roughly at rest or moving gently: gravity plus noise
            s.ax = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
            s.ay = $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
            s.az = 16'sd16384 + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            s.gx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            s.gy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            s.us = 16'($urandom_range(1000, 3000));
        end else if (k == 5) begin
            // fast spin: long steps at full rate push the estimates to saturation
            s.gx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            s.gy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            s.us = 16'($urandom_range(40000, 65535));
        end else if (k == 6) begin
            // ay and az zero, sometimes ax too, sometimes no integration
            s.ay = '0; s.az = '0;
            if ($urandom_range(0, 1)) s.ax = '0;
            if ($urandom_range(0, 3) == 0) s.us = '0;
        end
        return s;
    endfunction

    // directed table: extremes and special cases, angles typed where obvious
    t_sample directed [] = '{
        mk(0, 0, 0, 0, 0, 1, 1, 0, 0),               // zero vector straight after reset
        mk(0, 0, 0, 0, 0, 0, 1, 0, 0),               // zero vector, zero step
        mk(0, 0, 16384, 0, 0, 2000),                 // level, 1 g down
        mk(16384, 0, 0, 0, 0, 2000),
        mk(0, -16384, 0, 0, 0, 2000),
        mk(0, 0, -16384, 0, 0, 2000),                // upside down
        mk(0, 16384, -16384, 0, 0, 2000),
        mk(0, -16384, -16384, 0, 0, 2000),
        mk(-32768, 0, 0, 0, 0, 2000),
        mk(32767, 32767, 32767, 32767, 32767, 65535),
        mk(-32768, -32768, -32768, -32768, -32768, 65535),
        mk(32767, -32768, 32767, -32768, 32767, 65535),
        mk(0, 0, 0, 32767, 32767, 0),                // rate with no step
        mk(0, 0, 16384, 32767, -32768, 65535),
        mk(0, 0, 16384, 32767, -32768, 65535),
        mk(0, 0, 16384, 32767, -32768, 65535),
        mk(-1, -1, -1, -1, -1, 65535),
        mk(1, 1, 1, 1, 1, 1),
        mk(0, 0, 16384, 0, 0, 2000)
    };

    // fixed weights for the later phases; extremes first
    bit [31:0] weight_plan [] = '{32'd0, 32'd65536, 32'd131071, 32'd32768, 32'd65535};

    initial begin
        int per_phase;
        weight      = 17'd64225;
        roll_est    = 0;
        pitch_est   = 0;
        burst_left  = 0;
        cur_sample  = mk(0, 0, 0, 0, 0, 0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_sample(directed[i]);

        per_phase = NumRandom / (weight_plan.size() + 1);
        repeat (per_phase) send_sample(random_sample());
        foreach (weight_plan[p]) begin
            set_weight(weight_plan[p]);
            repeat (per_phase) send_sample(random_sample());
        end
        set_weight(32'd64225 + $urandom_range(0, 1000));
        repeat (20) send_sample(random_sample());
        i_in_valid <= 1'b0;

        wait (pending_motion.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        if (pending_motion.size() != 0) n_bad++;

        $display("%0d samples in, %0d results out, %0d weight settings, long hold-off %0s",
                 n_in, n_out, n_weights + 1, hold_done ? "done" : "missed");
        if (n_bad == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad results", n_bad);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
